// ===== rtl/core/onb2d_pkg.sv =====
// Shared types and constants for the 2-D orthonormal basis pipeline.
package onb2d_pkg;

	localparam int IN_W   = 16;
	localparam int OUT_W  = 16;
	localparam int NORM_W = 32;
	localparam int ROOT_W = 32;
	localparam int SQ_W   = 64;
	localparam int SH_W   = 5;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO     = 2'd1,
		ST_EQUAL    = 2'd2,
		ST_PARALLEL = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [IN_W-1:0] first_x;
		logic signed [IN_W-1:0] first_y;
		logic signed [IN_W-1:0] second_x;
		logic signed [IN_W-1:0] second_y;
	} req_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] basis_one_x;
		logic signed [OUT_W-1:0] basis_one_y;
		logic signed [OUT_W-1:0] basis_two_x;
		logic signed [OUT_W-1:0] basis_two_y;
		status_t                 status;
	} rsp_t;

	typedef struct packed {
		status_t             status;
		logic                neg_x;
		logic                neg_y;
		logic                cross_pos;
		logic [NORM_W-1:0]   nx;
		logic [NORM_W-1:0]   ny;
	} side_t;

endpackage

// ===== rtl/core/orthonormal_basis_2d.sv =====
// Throughput: one word per cycle; the whole pipeline holds while a result is stalled.
// Depth is set by the square root (one root bit per stage) and the two divide lanes
// (one quotient bit per stage).
// Reset clears the stage valid bits only; payload registers are not reset.
module orthonormal_basis_2d #(
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  onb2d_pkg::req_t  req,
	input  logic             req_valid,
	output logic             req_stall,
	output onb2d_pkg::rsp_t  rsp,
	output logic             rsp_valid,
	input  logic             rsp_stall
);
	import onb2d_pkg::*;

	localparam int QW  = OUT_FRAC_BITS + 2;
	localparam int DW  = NORM_W + OUT_FRAC_BITS + 3;
	localparam int SRW = ROOT_W + 3;

	logic adv;
	assign adv       = !(rsp_valid & rsp_stall);
	assign req_stall = !adv;

	// ---------------- stage 1: checks, cross terms, magnitudes
	logic                    v_s1;
	logic                    zero_s1, equal_s1, negx_s1, negy_s1;
	logic signed [2*IN_W-1:0] p_s1, q_s1;
	logic [IN_W-1:0]         nx_s1, ny_s1;

	logic signed [2*IN_W-1:0] p_d, q_d;
	assign p_d = req.first_x * req.second_y;
	assign q_d = req.first_y * req.second_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s1  <= (req.first_x == '0 && req.first_y == '0) ||
				(req.second_x == '0 && req.second_y == '0);
			equal_s1 <= (req.first_x == req.second_x) && (req.first_y == req.second_y);
			p_s1     <= p_d;
			q_s1     <= q_d;
			negx_s1  <= req.first_x[IN_W-1];
			negy_s1  <= req.first_y[IN_W-1];
			nx_s1    <= req.first_x[IN_W-1] ? (~req.first_x + 1'b1) : req.first_x;
			ny_s1    <= req.first_y[IN_W-1] ? (~req.first_y + 1'b1) : req.first_y;
		end
	end

	// ---------------- stage 2: status, normalizing shift amount
	logic              v_s2;
	side_t             side_s2;
	logic [SH_W-1:0]   sh_s2;

	logic [NORM_W-1:0] big;
	logic [SH_W-1:0]   hi_pos, sh_d;
	status_t           st_d;

	always_comb begin
		big    = (nx_s1 > ny_s1) ? NORM_W'(nx_s1) : NORM_W'(ny_s1);
		hi_pos = '0;
		for (int i = 0; i < NORM_W; i++) begin
			if (big[i]) hi_pos = SH_W'(i);
		end
		sh_d = big[NORM_W-1] ? '0 : (SH_W'(NORM_W - 2) - hi_pos);
		if (zero_s1)          st_d = ST_ZERO;
		else if (equal_s1)    st_d = ST_EQUAL;
		else if (p_s1 == q_s1) st_d = ST_PARALLEL;
		else                  st_d = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2.status    <= st_d;
			side_s2.neg_x     <= negx_s1;
			side_s2.neg_y     <= negy_s1;
			side_s2.cross_pos <= (p_s1 > q_s1);
			side_s2.nx        <= NORM_W'(nx_s1);
			side_s2.ny        <= NORM_W'(ny_s1);
			sh_s2             <= sh_d;
		end
	end

	// ---------------- stage 3: shift both magnitudes together
	logic  v_s3;
	side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.status    <= side_s2.status;
			side_s3.neg_x     <= side_s2.neg_x;
			side_s3.neg_y     <= side_s2.neg_y;
			side_s3.cross_pos <= side_s2.cross_pos;
			side_s3.nx        <= side_s2.nx << sh_s2;
			side_s3.ny        <= side_s2.ny << sh_s2;
		end
	end

	// ---------------- stage 4: squares
	logic            v_s4;
	side_t           side_s4;
	logic [SQ_W-1:0] sqx_s4, sqy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_s3;
			sqx_s4  <= SQ_W'(side_s3.nx) * SQ_W'(side_s3.nx);
			sqy_s4  <= SQ_W'(side_s3.ny) * SQ_W'(side_s3.ny);
		end
	end

	// ---------------- square root: one root bit per stage
	logic              sq_v_s    [0:ROOT_W];
	side_t             sq_side_s [0:ROOT_W];
	logic [SRW-1:0]    sq_rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] sq_root_s [0:ROOT_W];
	logic [SQ_W-1:0]   sq_l_s    [0:ROOT_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (adv) begin
			sq_v_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_side_s[0] <= side_s4;
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_l_s[0]    <= sqx_s4 + sqy_s4;
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic [SRW-1:0] rem_in, trial;
		logic           take;

		assign rem_in = {sq_rem_s[k][SRW-3:0], sq_l_s[k][SQ_W-1 -: 2]};
		assign trial  = SRW'({sq_root_s[k], 2'b01});
		assign take   = (rem_in >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_side_s[k+1] <= sq_side_s[k];
				sq_rem_s[k+1]  <= take ? (rem_in - trial) : rem_in;
				sq_root_s[k+1] <= {sq_root_s[k][ROOT_W-2:0], take};
			end
		end

		if (k < ROOT_W - 1) begin : g_feed
			always_ff @(posedge clk) begin
				if (adv) begin
					sq_l_s[k+1] <= {sq_l_s[k][SQ_W-3:0], 2'b00};
				end
			end
		end
	end

	// ---------------- divide: two lanes, one quotient bit per stage
	logic          dv_v_s    [0:QW];
	side_t         dv_side_s [0:QW];
	logic [DW-1:0] dv_rx_s   [0:QW];
	logic [DW-1:0] dv_ry_s   [0:QW];
	logic [ROOT_W:0] dv_den_s [0:QW-1];
	logic [QW-1:0] dv_qx_s   [0:QW];
	logic [QW-1:0] dv_qy_s   [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= sq_v_s[ROOT_W];
		end
	end

	// round half up: (n * 2^(F+1) + s) / (2 s)
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_side_s[0] <= sq_side_s[ROOT_W];
			dv_rx_s[0]   <= (DW'(sq_side_s[ROOT_W].nx) << (OUT_FRAC_BITS + 1)) +
				DW'(sq_root_s[ROOT_W]);
			dv_ry_s[0]   <= (DW'(sq_side_s[ROOT_W].ny) << (OUT_FRAC_BITS + 1)) +
				DW'(sq_root_s[ROOT_W]);
			dv_den_s[0]  <= {sq_root_s[ROOT_W], 1'b0};
			dv_qx_s[0]   <= '0;
			dv_qy_s[0]   <= '0;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int B = QW - 1 - j;
		logic [DW-1:0] dsh;
		logic          tx, ty;

		assign dsh = DW'(dv_den_s[j]) << B;
		assign tx  = (dv_rx_s[j] >= dsh);
		assign ty  = (dv_ry_s[j] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_side_s[j+1]  <= dv_side_s[j];
				dv_rx_s[j+1]    <= tx ? (dv_rx_s[j] - dsh) : dv_rx_s[j];
				dv_ry_s[j+1]    <= ty ? (dv_ry_s[j] - dsh) : dv_ry_s[j];
				dv_qx_s[j+1]    <= dv_qx_s[j] | (QW'(tx) << B);
				dv_qy_s[j+1]    <= dv_qy_s[j] | (QW'(ty) << B);
			end
		end

		if (j < QW - 1) begin : g_den
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_den_s[j+1] <= dv_den_s[j];
				end
			end
		end
	end

	// ---------------- output register
	function automatic logic [OUT_W-1:0] to_field(logic [QW-1:0] q, logic neg);
		logic [31:0]      w;
		logic [OUT_W-1:0] m;
		w = 32'(q);
		m = (w > 32'd32767) ? OUT_W'(32767) : OUT_W'(w);
		return neg ? (~m + 1'b1) : m;
	endfunction

	side_t            fin;
	logic [OUT_W-1:0] e1x, e1y, e2x, e2y;
	rsp_t             rsp_d;

	always_comb begin
		fin = dv_side_s[QW];
		e1x = to_field(dv_qx_s[QW], fin.neg_x);
		e1y = to_field(dv_qy_s[QW], fin.neg_y);
		if (fin.cross_pos) begin
			e2x = ~e1y + 1'b1;
			e2y = e1x;
		end else begin
			e2x = e1y;
			e2y = ~e1x + 1'b1;
		end
		rsp_d.status = fin.status;
		if (fin.status == ST_OK) begin
			rsp_d.basis_one_x = e1x;
			rsp_d.basis_one_y = e1y;
			rsp_d.basis_two_x = e2x;
			rsp_d.basis_two_y = e2y;
		end else begin
			rsp_d.basis_one_x = '0;
			rsp_d.basis_one_y = '0;
			rsp_d.basis_two_x = '0;
			rsp_d.basis_two_y = '0;
		end
	end

	logic rsp_valid_q;
	rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= dv_v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------- checks
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |->
			rsp.basis_one_x == '0 && rsp.basis_one_y == '0 &&
			rsp.basis_two_x == '0 && rsp.basis_two_y == '0)
		else $error("error word carries nonzero vectors");

	a_rotated: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_OK |->
			(rsp.basis_two_x == -rsp.basis_one_y && rsp.basis_two_y == rsp.basis_one_x) ||
			(rsp.basis_two_x == rsp.basis_one_y && rsp.basis_two_y == -rsp.basis_one_x))
		else $error("second basis vector is not a quarter turn of the first");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_OK |->
			rsp.basis_one_x != '0 || rsp.basis_one_y != '0)
		else $error("unit vector came out zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled without a stalled result");

endmodule
